FILE: hdl/sqo_pkg.sv
// Package: sizes, opcodes, status codes, FSM states, ring helpers and value conversions.
`timescale 1ns / 1ps
package sqo_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;

  localparam logic [2:0] ACT_PUSH  = 3'd0;
  localparam logic [2:0] ACT_PRINT = 3'd1;
  localparam logic [2:0] ACT_PEEK  = 3'd2;
  localparam logic [2:0] ACT_POP   = 3'd3;
  localparam logic [2:0] ACT_SWAP  = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BADARG     = 3'd1;
  localparam logic [2:0] ST_PEEK_EMPTY = 3'd2;
  localparam logic [2:0] ST_POP_EMPTY  = 3'd3;
  localparam logic [2:0] ST_SWAP_SHORT = 3'd4;
  localparam logic [2:0] ST_FULL       = 3'd5;
  localparam logic [2:0] ST_HALTED     = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PEEK,
    S_PRINT,
    S_SWAP_A,
    S_SWAP_B,
    S_SWAP_C
  } state_t;

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] word_t;

  function automatic ptr_t ring_add(input ptr_t ptr, input cnt_t off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(ptr) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) s = s - SUM_W'(DEPTH);
    return s[PTR_W-1:0];
  endfunction

  function automatic ptr_t ring_dec(input ptr_t ptr);
    ptr_t r;
    if (ptr == '0) r = PTR_W'(DEPTH - 1);
    else r = ptr - PTR_W'(1);
    return r;
  endfunction

  function automatic word_t to_store(input logic signed [31:0] v);
    logic [63:0] e;
    e = 64'(v);
    return e[DATA_WIDTH-1:0];
  endfunction

  function automatic logic signed [31:0] to_out(input word_t w);
    logic [63:0] e;
    e = 64'($signed(w));
    return $signed(e[31:0]);
  endfunction

endpackage

FILE: hdl/stack_queue_opcode_unit.sv
// Top level: stack / queue opcode unit around one entry RAM.
//
// Input channel (in_*): one opcode item per handshake (in_valid high, in_stall
// low). The unit takes one item at a time; in_stall is high while an item is
// being worked on. Result channel (out_*): items leave an output register,
// each accepted when out_valid is high and out_stall low.
// Steps per item, set by the single RAM read port with its registered read data:
//   push, pop, errors, halted, unused codes: result emitted in S_EXEC;
//   peek: read in S_EXEC, result in S_PEEK; swap: S_EXEC, S_SWAP_A, S_SWAP_B,
//   S_SWAP_C (two reads, two writes); print all: read in S_EXEC, then one result
//   per cycle in S_PRINT while out_stall stays low.
// Configuration: cfg_we writes cfg_wdata into lifo_mode (1 stack, 0 queue);
// write only while the unit is idle.
// Reset (rst_n low, synchronous): front pointer, entry count and halted flag
// clear, lifo_mode returns to 1, the output register empties. The RAM is not
// cleared; entries are only read after they are written.
// A stalled receiver holds the output register; each step that emits a result
// waits until the register can take it.
module stack_queue_opcode_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_push_value,
  input  logic               in_arg_ok,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_data,
  output logic               out_data_valid,
  output logic [2:0]         out_status,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  sqo_pkg::state_t state_r, state_nxt;
  logic [2:0]      act_r;
  sqo_pkg::word_t  val_r;
  logic            ok_r;
  sqo_pkg::ptr_t   front_r, front_nxt;
  sqo_pkg::cnt_t   cnt_r, cnt_nxt;
  logic            halted_r, halted_nxt;
  sqo_pkg::ptr_t   idx_r, idx_nxt;
  sqo_pkg::word_t  tmp_r, tmp_nxt;
  logic            lifo_mode_r;

  logic               out_valid_r;
  logic signed [31:0] out_data_r;
  logic               out_data_valid_r;
  logic [2:0]         out_status_r;
  logic               out_last_r;

  logic               emit;
  logic signed [31:0] e_data;
  logic               e_dv;
  logic [2:0]         e_st;
  logic               e_last;

  logic           mem_we, mem_re;
  sqo_pkg::ptr_t  mem_waddr, mem_raddr;
  sqo_pkg::word_t mem_wdata, mem_rdata;

  logic in_accept, out_free, print_last;

  assign in_stall  = (state_r != sqo_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign print_last = (sqo_pkg::CNT_W'(idx_r) == cnt_r - sqo_pkg::CNT_W'(1));

  sqo_ram #(
    .DEPTH  (sqo_pkg::DEPTH),
    .ADDR_W (sqo_pkg::PTR_W),
    .DATA_W (sqo_pkg::DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    front_nxt  = front_r;
    cnt_nxt    = cnt_r;
    halted_nxt = halted_r;
    idx_nxt    = idx_r;
    tmp_nxt    = tmp_r;
    mem_we     = 1'b0;
    mem_waddr  = front_r;
    mem_wdata  = val_r;
    mem_re     = 1'b0;
    mem_raddr  = front_r;
    emit       = 1'b0;
    e_data     = '0;
    e_dv       = 1'b0;
    e_st       = sqo_pkg::ST_OK;
    e_last     = 1'b1;
    case (state_r)
      sqo_pkg::S_IDLE: begin
        if (in_accept) state_nxt = sqo_pkg::S_EXEC;
      end
      sqo_pkg::S_EXEC: begin
        if (halted_r) begin
          if (out_free) begin
            emit      = 1'b1;
            e_st      = sqo_pkg::ST_HALTED;
            state_nxt = sqo_pkg::S_IDLE;
          end
        end else begin
          case (act_r)
            sqo_pkg::ACT_PUSH: begin
              if (out_free) begin
                emit      = 1'b1;
                state_nxt = sqo_pkg::S_IDLE;
                if (!ok_r) begin
                  e_st       = sqo_pkg::ST_BADARG;
                  halted_nxt = 1'b1;
                end else if (cnt_r == sqo_pkg::CNT_W'(sqo_pkg::DEPTH)) begin
                  e_st       = sqo_pkg::ST_FULL;
                  halted_nxt = 1'b1;
                end else begin
                  mem_we  = 1'b1;
                  cnt_nxt = cnt_r + sqo_pkg::CNT_W'(1);
                  if (lifo_mode_r) begin
                    front_nxt = sqo_pkg::ring_dec(front_r);
                    mem_waddr = sqo_pkg::ring_dec(front_r);
                  end else begin
                    mem_waddr = sqo_pkg::ring_add(front_r, cnt_r);
                  end
                end
              end
            end
            sqo_pkg::ACT_PRINT: begin
              if (cnt_r == '0) begin
                if (out_free) begin
                  emit      = 1'b1;
                  state_nxt = sqo_pkg::S_IDLE;
                end
              end else begin
                mem_re    = 1'b1;
                idx_nxt   = '0;
                state_nxt = sqo_pkg::S_PRINT;
              end
            end
            sqo_pkg::ACT_PEEK: begin
              if (cnt_r == '0) begin
                if (out_free) begin
                  emit       = 1'b1;
                  e_st       = sqo_pkg::ST_PEEK_EMPTY;
                  halted_nxt = 1'b1;
                  state_nxt  = sqo_pkg::S_IDLE;
                end
              end else begin
                mem_re    = 1'b1;
                state_nxt = sqo_pkg::S_PEEK;
              end
            end
            sqo_pkg::ACT_POP: begin
              if (out_free) begin
                emit      = 1'b1;
                state_nxt = sqo_pkg::S_IDLE;
                if (cnt_r == '0) begin
                  e_st       = sqo_pkg::ST_POP_EMPTY;
                  halted_nxt = 1'b1;
                end else begin
                  front_nxt = sqo_pkg::ring_add(front_r, sqo_pkg::CNT_W'(1));
                  cnt_nxt   = cnt_r - sqo_pkg::CNT_W'(1);
                end
              end
            end
            sqo_pkg::ACT_SWAP: begin
              if (cnt_r < sqo_pkg::CNT_W'(2)) begin
                if (out_free) begin
                  emit       = 1'b1;
                  e_st       = sqo_pkg::ST_SWAP_SHORT;
                  halted_nxt = 1'b1;
                  state_nxt  = sqo_pkg::S_IDLE;
                end
              end else begin
                mem_re    = 1'b1;
                state_nxt = sqo_pkg::S_SWAP_A;
              end
            end
            default: begin
              if (out_free) begin
                emit      = 1'b1;
                state_nxt = sqo_pkg::S_IDLE;
              end
            end
          endcase
        end
      end
      sqo_pkg::S_PEEK: begin
        if (out_free) begin
          emit      = 1'b1;
          e_data    = sqo_pkg::to_out(mem_rdata);
          e_dv      = 1'b1;
          state_nxt = sqo_pkg::S_IDLE;
        end
      end
      sqo_pkg::S_PRINT: begin
        if (out_free) begin
          emit   = 1'b1;
          e_data = sqo_pkg::to_out(mem_rdata);
          e_dv   = 1'b1;
          e_last = print_last;
          if (print_last) begin
            state_nxt = sqo_pkg::S_IDLE;
          end else begin
            idx_nxt   = idx_r + sqo_pkg::PTR_W'(1);
            mem_re    = 1'b1;
            mem_raddr = sqo_pkg::ring_add(front_r,
                          sqo_pkg::CNT_W'(idx_r) + sqo_pkg::CNT_W'(1));
          end
        end
      end
      sqo_pkg::S_SWAP_A: begin
        tmp_nxt   = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = sqo_pkg::ring_add(front_r, sqo_pkg::CNT_W'(1));
        state_nxt = sqo_pkg::S_SWAP_B;
      end
      sqo_pkg::S_SWAP_B: begin
        mem_we    = 1'b1;
        mem_waddr = front_r;
        mem_wdata = mem_rdata;
        state_nxt = sqo_pkg::S_SWAP_C;
      end
      sqo_pkg::S_SWAP_C: begin
        if (out_free) begin
          mem_we    = 1'b1;
          mem_waddr = sqo_pkg::ring_add(front_r, sqo_pkg::CNT_W'(1));
          mem_wdata = tmp_r;
          emit      = 1'b1;
          state_nxt = sqo_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sqo_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sqo_pkg::S_IDLE;
      front_r     <= '0;
      cnt_r       <= '0;
      halted_r    <= 1'b0;
      lifo_mode_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      front_r  <= front_nxt;
      cnt_r    <= cnt_nxt;
      halted_r <= halted_nxt;
      if (cfg_we) lifo_mode_r <= cfg_wdata;
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    tmp_r <= tmp_nxt;
    if (in_accept) begin
      act_r <= in_action;
      val_r <= sqo_pkg::to_store(in_push_value);
      ok_r  <= in_arg_ok;
    end
    if (emit) begin
      out_data_r       <= e_data;
      out_data_valid_r <= e_dv;
      out_status_r     <= e_st;
      out_last_r       <= e_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign out_data_valid = out_data_valid_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= sqo_pkg::CNT_W'(sqo_pkg::DEPTH))
    else $error("entry count above depth");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r && $stable(cnt_r) && $stable(front_r))
    else $error("halted unit changed state");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != sqo_pkg::ST_OK |-> out_last_r && !out_data_valid_r)
    else $error("error result not a single last item");

  a_we_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r != sqo_pkg::S_IDLE && !halted_r)
    else $error("RAM write outside an active item");
`endif

endmodule

FILE: hdl/sqo_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module sqo_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: test/testbench.sv
// Testbench for stack_queue_opcode_unit: directed and random opcode items checked against a behavioral deque.
`timescale 1ns / 1ps
module testbench;

  localparam logic [2:0] ACT_SPARE_5 = 3'd5;
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  typedef enum int {
    BREAK_BADARG,
    BREAK_PEEK,
    BREAK_POP,
    BREAK_SWAP,
    BREAK_FULL
  } break_t;

  typedef struct packed {
    logic [31:0] data;
    logic        valid;
    logic [2:0]  status;
    logic        last;
  } result_t;

  class deque_tracker;
    logic [31:0]             ring_mem [sqo_pkg::DEPTH];
    bit [sqo_pkg::PTR_W-1:0] front;
    int                      count;
    bit                      halted;
    bit                      lifo;
    result_t                 pending_results[$];
    int                      errors;

    function new();
      front = '0;
      count = 0;
      halted = 1'b0;
      lifo = 1'b1;
      errors = 0;
    endfunction

    function void set_mode(bit v);
      lifo = v;
    endfunction

    function void add_result(logic [31:0] d, logic v, logic [2:0] s, logic l);
      result_t r;
      r.data = d;
      r.valid = v;
      r.status = s;
      r.last = l;
      pending_results.push_back(r);
    endfunction

    function void halt_with(logic [2:0] code);
      halted = 1'b1;
      add_result('0, 1'b0, code, 1'b1);
    endfunction

    function void apply_opcode(logic [2:0] act, logic [31:0] val, logic ok);
      bit [sqo_pkg::PTR_W-1:0] slot;
      bit [sqo_pkg::PTR_W-1:0] next;
      logic [31:0]             t;
      if (halted) begin
        add_result('0, 1'b0, sqo_pkg::ST_HALTED, 1'b1);
        return;
      end
      case (act)
        sqo_pkg::ACT_PUSH: begin
          if (!ok) begin
            halt_with(sqo_pkg::ST_BADARG);
            return;
          end
          if (count >= sqo_pkg::DEPTH) begin
            halt_with(sqo_pkg::ST_FULL);
            return;
          end
          if (lifo) begin
            front = front - sqo_pkg::PTR_W'(1);
            ring_mem[front] = val;
          end else begin
            slot = front + sqo_pkg::PTR_W'(count);
            ring_mem[slot] = val;
          end
          count++;
        end
        sqo_pkg::ACT_PRINT: begin
          if (count > 0) begin
            for (int i = 0; i < count; i++) begin
              slot = front + sqo_pkg::PTR_W'(i);
              add_result(ring_mem[slot], 1'b1, sqo_pkg::ST_OK, i == count - 1);
            end
            return;
          end
        end
        sqo_pkg::ACT_PEEK: begin
          if (count == 0) begin
            halt_with(sqo_pkg::ST_PEEK_EMPTY);
            return;
          end
          add_result(ring_mem[front], 1'b1, sqo_pkg::ST_OK, 1'b1);
          return;
        end
        sqo_pkg::ACT_POP: begin
          if (count == 0) begin
            halt_with(sqo_pkg::ST_POP_EMPTY);
            return;
          end
          front = front + sqo_pkg::PTR_W'(1);
          count--;
        end
        sqo_pkg::ACT_SWAP: begin
          if (count < 2) begin
            halt_with(sqo_pkg::ST_SWAP_SHORT);
            return;
          end
          next = front + sqo_pkg::PTR_W'(1);
          t = ring_mem[front];
          ring_mem[front] = ring_mem[next];
          ring_mem[next] = t;
        end
        default: begin
        end
      endcase
      add_result('0, 1'b0, sqo_pkg::ST_OK, 1'b1);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("mismatch: %s", msg);
    endtask

    task match_result(logic [31:0] d, logic v, logic [2:0] s, logic l);
      result_t e;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected item data=%h dv=%b st=%0d last=%b", d, v, s, l));
        return;
      end
      e = pending_results.pop_front();
      if (e.data !== d || e.valid !== v || e.status !== s || e.last !== l)
        report($sformatf("data %h/%h dv %b/%b st %0d/%0d last %b/%b (got/exp)",
                         d, e.data, v, e.valid, s, e.status, l, e.last));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_action = sqo_pkg::ACT_PUSH;
  logic signed [31:0] in_push_value = '0;
  logic               in_arg_ok = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_data;
  logic               out_data_valid;
  logic [2:0]         out_status;
  logic               out_last;
  logic               cfg_we = 1'b0;
  logic               cfg_wdata = 1'b1;

  deque_tracker board;
  int           burst_left = 0;
  int           stall_mode = 0;
  int           stall_left = 0;

  stack_queue_opcode_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_push_value  (in_push_value),
    .in_arg_ok      (in_arg_ok),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .out_data_valid (out_data_valid),
    .out_status     (out_status),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(3);
      stall_left <= $urandom_range(10, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(99) < 30);
      2: out_stall <= ($urandom_range(99) < 70);
      default: out_stall <= (stall_left % 3 == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.match_result(out_data, out_data_valid, out_status, out_last);
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic [2:0] act, logic [31:0] val, logic ok);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_push_value <= val;
    in_arg_ok <= ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.apply_opcode(act, val, ok);
    burst_left--;
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(bit v);
    go_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_mode(v);
  endtask

  task automatic send_random(int push_pct);
    logic [2:0] act;
    act = sqo_pkg::ACT_PUSH;
    if ($urandom_range(99) >= push_pct) begin
      case ($urandom_range(9))
        0, 1, 2: act = sqo_pkg::ACT_POP;
        3, 4:    act = sqo_pkg::ACT_PEEK;
        5, 6:    act = sqo_pkg::ACT_SWAP;
        7:       act = sqo_pkg::ACT_PRINT;
        8:       act = ACT_SPARE_5 + 3'($urandom_range(2));
        default: act = sqo_pkg::ACT_PRINT;
      endcase
      if ((act == sqo_pkg::ACT_POP || act == sqo_pkg::ACT_PEEK) && board.count == 0)
        act = sqo_pkg::ACT_PUSH;
      if (act == sqo_pkg::ACT_SWAP && board.count < 2) act = sqo_pkg::ACT_PUSH;
    end
    if (act == sqo_pkg::ACT_PUSH && board.count >= sqo_pkg::DEPTH) act = sqo_pkg::ACT_POP;
    send_item(act, pick_value(),
              (act == sqo_pkg::ACT_PUSH) ? 1'b1 : 1'($urandom_range(1)));
  endtask

  initial begin
    int     push_pct [6];
    break_t kind;
    push_pct = '{60, 50, 25, 55, 40, 50};
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(sqo_pkg::ACT_PRINT, 32'h0, 1'b0);
    send_item(sqo_pkg::ACT_PUSH, 32'h7FFF_FFFF, 1'b1);
    send_item(sqo_pkg::ACT_PUSH, 32'h8000_0000, 1'b1);
    send_item(sqo_pkg::ACT_PUSH, 32'h0000_0000, 1'b1);
    send_item(sqo_pkg::ACT_PUSH, 32'hFFFF_FFFF, 1'b1);
    send_item(sqo_pkg::ACT_PEEK, 32'h0, 1'b1);
    send_item(sqo_pkg::ACT_PRINT, 32'h0, 1'b1);
    send_item(sqo_pkg::ACT_SWAP, 32'h0, 1'b0);
    send_item(sqo_pkg::ACT_PEEK, 32'h0, 1'b0);
    send_item(sqo_pkg::ACT_POP, 32'h0, 1'b1);
    send_item(ACT_SPARE_5, 32'hFFFF_FFFF, 1'b0);
    send_item(ACT_SPARE_6, 32'h0, 1'b1);
    send_item(ACT_SPARE_7, 32'h1234_5678, 1'b0);
    send_item(sqo_pkg::ACT_PRINT, 32'h0, 1'b0);
    write_mode(1'b0);
    send_item(sqo_pkg::ACT_PUSH, 32'h0000_0001, 1'b1);
    send_item(sqo_pkg::ACT_PUSH, 32'h5555_5555, 1'b1);
    send_item(sqo_pkg::ACT_PUSH, 32'hAAAA_AAAA, 1'b1);
    send_item(sqo_pkg::ACT_PRINT, 32'h0, 1'b1);
    send_item(sqo_pkg::ACT_SWAP, 32'h0, 1'b1);
    send_item(sqo_pkg::ACT_POP, 32'h0, 1'b0);
    send_item(sqo_pkg::ACT_PRINT, 32'h0, 1'b0);
    send_item(sqo_pkg::ACT_PEEK, 32'h0, 1'b1);

    for (int p = 0; p < 6; p++) begin
      write_mode(p % 2 == 0);
      if (p == 2) begin
        while (board.count < sqo_pkg::DEPTH) send_item(sqo_pkg::ACT_PUSH, pick_value(), 1'b1);
        send_item(sqo_pkg::ACT_PRINT, 32'h0, 1'b1);
        send_item(sqo_pkg::ACT_SWAP, 32'h0, 1'b0);
        send_item(sqo_pkg::ACT_PEEK, 32'h0, 1'b1);
      end
      repeat (8) send_random(push_pct[p]);
    end

    write_mode(1'($urandom_range(1)));
    kind = break_t'($urandom_range(4));
    case (kind)
      BREAK_BADARG: send_item(sqo_pkg::ACT_PUSH, pick_value(), 1'b0);
      BREAK_PEEK: begin
        while (board.count > 0) send_item(sqo_pkg::ACT_POP, pick_value(), 1'b1);
        send_item(sqo_pkg::ACT_PEEK, pick_value(), 1'b1);
      end
      BREAK_POP: begin
        while (board.count > 0) send_item(sqo_pkg::ACT_POP, pick_value(), 1'b0);
        send_item(sqo_pkg::ACT_POP, pick_value(), 1'b1);
      end
      BREAK_SWAP: begin
        while (board.count > 1) send_item(sqo_pkg::ACT_POP, pick_value(), 1'b1);
        send_item(sqo_pkg::ACT_SWAP, pick_value(), 1'b1);
      end
      default: begin
        while (board.count < sqo_pkg::DEPTH) send_item(sqo_pkg::ACT_PUSH, pick_value(), 1'b1);
        send_item(sqo_pkg::ACT_PUSH, pick_value(), 1'b1);
      end
    endcase
    repeat (6) send_item(3'($urandom_range(7)), $urandom, 1'($urandom_range(1)));

    go_idle();
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: stack_queue_opcode_unit.f
hdl/sqo_pkg.sv
hdl/sqo_ram.sv
hdl/stack_queue_opcode_unit.sv
test/testbench.sv
